/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define PLL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold.
`define PLL_ASSERT_NEVER(label, expr, msg) \
	`PLL_ASSERT(label, !(expr), msg)

`endif

/* rtl/pll_pkg.sv */
// Shared constants, codes and transaction types of the linked list engine.
`timescale 1ns / 1ps
package pll_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 2;
	localparam int ECNT_W   = 6;

	localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DEL_POS  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_UPDATE   = 3'd6;
	localparam logic [ACT_W-1:0] ACT_TRAVERSE = 3'd7;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic signed [VAL_W-1:0] item_value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic [ST_W-1:0]         status;
		logic [ECNT_W-1:0]       element_count;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t item;
	} emit_t;

endpackage

/* rtl/positional_linked_list_engine.sv */
// Top level of the positional linked list engine: sequencer and result register.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one action per transaction:
//   insert head, tail or position; delete head, tail or position; update; traverse.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one status transaction per
//   action, or one transaction per element for traverse with last on the final one.
//   One action is worked on at a time; req_stall is high until it has finished.
//   After acceptance the action is decoded: full, empty or a bad position is reported
//   without a walk, as are head inserts and deletes; other actions walk the links
//   from the head as far as their position needs before the list is changed or
//   the value updated. Traverse reads out one element per cycle while the output
//   slot is free. The engine is ready for the next action in the cycle after the
//   result is loaded.
//   After reset the link memory is chained into the free list with req_stall high;
//   the list then starts empty.
//   A result waiting in the output register does not block the next action; while
//   rsp_stall holds, the following result waits in the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module positional_linked_list_engine
	import pll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	emit_t emit;
	logic  slot_free;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	pll_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.busy(req_stall),
		.emit(emit),
		.slot_free(slot_free)
	);

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit.valid && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && slot_free) begin
			rsp_q <= emit.item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PLL_ASSERT(a_count_bound, rsp_valid |-> rsp.element_count <= ECNT_W'(CAPACITY), "bad count")
	`PLL_ASSERT(a_err_last, rsp_valid && rsp.status != ST_OK |-> rsp.last, "error not last")
	`PLL_ASSERT_NEVER(a_err_val, rsp_valid && rsp.status != ST_OK && rsp.out_value != '0, "err value")
	`PLL_ASSERT(a_emit_held, emit.valid && !slot_free |=> emit.valid, "pending result dropped")

endmodule

/* rtl/pll_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/pll_ctrl.sv */
// List sequencer: node value and link memories, free list, walks and updates.
`timescale 1ns / 1ps
module pll_ctrl
	import pll_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  req_t  req,
	output logic  busy,
	output emit_t emit,
	input  logic  slot_free
);

	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECODE, S_WALK, S_AT, S_INS_F2, S_INS_P, S_INS_L,
		S_DEL_H, S_DEL_V, S_DEL_N, S_DEL_F, S_TRAV_RD, S_TRAV_OUT, S_EMIT
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]        init_q, head_q, free_q, cur_q, nfree_q, victim_q;
	logic [CNT_W-1:0]        cnt_q, steps_q, n_q;
	logic [ACT_W-1:0]        act_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [ST_W-1:0]         st_q;
	logic                    p1_q;

	logic             lk_we, lk_re, vl_we, vl_re;
	logic [IDX_W-1:0] lk_waddr, lk_raddr, vl_waddr, vl_raddr, lk_wdata, lk_rdata;
	logic [VAL_W-1:0] vl_rdata;

	logic             is_ins, is_del, is_upd, is_trav;
	logic [CMP_W-1:0] cnt_x, pos_x, pe, k;
	logic [ST_W-1:0]  dec_st;
	logic             dec_p1, dec_walk;
	logic [CNT_W-1:0] dec_steps;

	pll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.re(lk_re), .raddr(lk_raddr), .rdata(lk_rdata)
	);

	pll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
		.clk(clk), .we(vl_we), .waddr(vl_waddr), .wdata(val_q),
		.re(vl_re), .raddr(vl_raddr), .rdata(vl_rdata)
	);

	assign cnt_x = CMP_W'(cnt_q);
	assign pos_x = CMP_W'(pos_q);

	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		is_upd  = 1'b0;
		is_trav = 1'b0;
		pe      = pos_x;
		case (act_q)
			ACT_INS_HEAD: begin is_ins = 1'b1; pe = CMP_W'(1); end
			ACT_INS_TAIL: begin is_ins = 1'b1; pe = cnt_x + CMP_W'(1); end
			ACT_INS_POS:  begin is_ins = 1'b1; end
			ACT_DEL_HEAD: begin is_del = 1'b1; pe = CMP_W'(1); end
			ACT_DEL_TAIL: begin is_del = 1'b1; pe = cnt_x; end
			ACT_DEL_POS:  begin is_del = 1'b1; end
			ACT_UPDATE:   begin is_upd = 1'b1; end
			default:      begin is_trav = 1'b1; end
		endcase
		dec_st = ST_OK;
		if (is_ins) begin
			if (cnt_q == CNT_W'(CAPACITY)) begin
				dec_st = ST_FULL;
			end else if (pe == '0 || pe > cnt_x + CMP_W'(1)) begin
				dec_st = ST_BAD;
			end
		end else if (cnt_q == '0) begin
			dec_st = ST_EMPTY;
		end else if (!is_trav && (pe == '0 || pe > cnt_x)) begin
			dec_st = ST_BAD;
		end
		k         = is_upd ? pe : pe - CMP_W'(1);
		dec_p1    = !is_upd && pe == CMP_W'(1);
		dec_steps = CNT_W'(k - CMP_W'(1));
		dec_walk  = dec_st == ST_OK && !is_trav && !dec_p1 && dec_steps != '0;
	end

	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = cur_q;
		lk_wdata = free_q;
		lk_re    = 1'b0;
		lk_raddr = cur_q;
		vl_we    = 1'b0;
		vl_waddr = free_q;
		vl_re    = 1'b0;
		vl_raddr = cur_q;
		case (state_q)
			S_INIT: begin
				lk_we    = 1'b1;
				lk_waddr = init_q;
				lk_wdata = (init_q == IDX_W'(CAPACITY - 1)) ? '0 : init_q + IDX_W'(1);
			end
			S_DECODE: begin
				lk_re    = dec_walk;
				lk_raddr = head_q;
			end
			S_WALK: begin
				lk_re    = steps_q != CNT_W'(1);
				lk_raddr = lk_rdata;
			end
			S_AT: begin
				if (is_ins) begin
					lk_re    = 1'b1;
					lk_raddr = free_q;
				end else if (is_del) begin
					lk_re    = 1'b1;
					lk_raddr = p1_q ? head_q : cur_q;
				end else begin
					vl_we    = 1'b1;
					vl_waddr = cur_q;
				end
			end
			S_INS_F2: begin
				if (p1_q) begin
					lk_we    = 1'b1;
					lk_waddr = free_q;
					lk_wdata = head_q;
					vl_we    = 1'b1;
				end else begin
					lk_re = 1'b1;
				end
			end
			S_INS_P: begin
				lk_we    = 1'b1;
				lk_waddr = free_q;
				lk_wdata = lk_rdata;
				vl_we    = 1'b1;
			end
			S_INS_L: begin
				lk_we = 1'b1;
			end
			S_DEL_H: begin
				lk_we    = 1'b1;
				lk_waddr = head_q;
			end
			S_DEL_V: begin
				lk_re    = 1'b1;
				lk_raddr = lk_rdata;
			end
			S_DEL_N: begin
				lk_we    = 1'b1;
				lk_wdata = lk_rdata;
			end
			S_DEL_F: begin
				lk_we    = 1'b1;
				lk_waddr = victim_q;
			end
			S_TRAV_RD: begin
				lk_re = 1'b1;
				vl_re = 1'b1;
			end
			S_TRAV_OUT: begin
				lk_re    = slot_free && n_q != CNT_W'(1);
				vl_re    = lk_re;
				lk_raddr = lk_rdata;
				vl_raddr = lk_rdata;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit.valid              = 1'b0;
		emit.item.out_value     = '0;
		emit.item.status        = st_q;
		emit.item.element_count = ECNT_W'(cnt_q);
		emit.item.last          = 1'b1;
		case (state_q)
			S_EMIT: begin
				emit.valid = 1'b1;
			end
			S_TRAV_OUT: begin
				emit.valid          = 1'b1;
				emit.item.out_value = vl_rdata;
				emit.item.status    = ST_OK;
				emit.item.last      = n_q == CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			head_q  <= '0;
			free_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + IDX_W'(1);
					if (init_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						act_q   <= req.action;
						val_q   <= req.item_value;
						pos_q   <= req.position;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					st_q    <= dec_st;
					p1_q    <= dec_p1;
					cur_q   <= head_q;
					n_q     <= cnt_q;
					steps_q <= dec_steps;
					if (dec_st != ST_OK) begin
						state_q <= S_EMIT;
					end else if (is_trav) begin
						state_q <= S_TRAV_RD;
					end else if (dec_walk) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_AT;
					end
				end
				S_WALK: begin
					cur_q   <= lk_rdata;
					steps_q <= steps_q - CNT_W'(1);
					if (steps_q == CNT_W'(1)) begin
						state_q <= S_AT;
					end
				end
				S_AT: begin
					if (is_ins) begin
						state_q <= S_INS_F2;
					end else if (is_del) begin
						state_q <= p1_q ? S_DEL_H : S_DEL_V;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_INS_F2: begin
					nfree_q <= lk_rdata;
					if (p1_q) begin
						head_q  <= free_q;
						free_q  <= lk_rdata;
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_INS_P;
					end
				end
				S_INS_P: begin
					state_q <= S_INS_L;
				end
				S_INS_L: begin
					free_q  <= nfree_q;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_DEL_H: begin
					head_q  <= lk_rdata;
					free_q  <= head_q;
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_DEL_V: begin
					victim_q <= lk_rdata;
					state_q  <= S_DEL_N;
				end
				S_DEL_N: begin
					state_q <= S_DEL_F;
				end
				S_DEL_F: begin
					free_q  <= victim_q;
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_TRAV_RD: begin
					state_q <= S_TRAV_OUT;
				end
				S_TRAV_OUT: begin
					if (slot_free) begin
						n_q <= n_q - CNT_W'(1);
						if (n_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sim/pll_list_checker.sv */
// Channel monitor with list predictor and result comparison for the linked list engine.
`timescale 1ns / 1ps
module pll_list_checker
	import pll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding,
	output int   list_len
);

	logic signed [VAL_W-1:0] list_q[$];
	rsp_t expected_rsp_q[$];
	int errors = 0;

	function automatic void push_status(input logic [ST_W-1:0] st);
		rsp_t e;
		e.out_value     = '0;
		e.status        = st;
		e.element_count = ECNT_W'(list_q.size());
		e.last          = 1'b1;
		expected_rsp_q.push_back(e);
	endfunction

	function automatic logic [ST_W-1:0] insert_at(input int p, input logic signed [VAL_W-1:0] v);
		if (list_q.size() >= CAPACITY)
			return ST_FULL;
		if (p < 1 || p > list_q.size() + 1)
			return ST_BAD;
		list_q.insert(p - 1, v);
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] delete_at(input int p);
		if (list_q.size() == 0)
			return ST_EMPTY;
		if (p < 1 || p > list_q.size())
			return ST_BAD;
		list_q.delete(p - 1);
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] update_at(input int p, input logic signed [VAL_W-1:0] v);
		if (list_q.size() == 0)
			return ST_EMPTY;
		if (p < 1 || p > list_q.size())
			return ST_BAD;
		list_q[p - 1] = v;
		return ST_OK;
	endfunction

	function automatic void apply_action(input req_t r);
		rsp_t e;
		int   pos;
		pos = int'(r.position);
		case (r.action)
			ACT_INS_HEAD: push_status(insert_at(1, r.item_value));
			ACT_INS_TAIL: push_status(insert_at(list_q.size() + 1, r.item_value));
			ACT_INS_POS:  push_status(insert_at(pos, r.item_value));
			ACT_DEL_HEAD: push_status(delete_at(1));
			ACT_DEL_TAIL: push_status(delete_at(list_q.size()));
			ACT_DEL_POS:  push_status(delete_at(pos));
			ACT_UPDATE:   push_status(update_at(pos, r.item_value));
			default: begin
				if (list_q.size() == 0) begin
					push_status(ST_EMPTY);
				end else begin
					for (int i = 0; i < list_q.size(); i++) begin
						e.out_value     = list_q[i];
						e.status        = ST_OK;
						e.element_count = ECNT_W'(list_q.size());
						e.last          = (i == list_q.size() - 1);
						expected_rsp_q.push_back(e);
					end
				end
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected value=%0d status=%0d count=%0d last=%0b, got value=%0d status=%0d count=%0d last=%0b",
				$realtime, what, want.out_value, want.status, want.element_count, want.last,
				got.out_value, got.status, got.element_count, got.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			list_q.delete();
			expected_rsp_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					note_mismatch("unexpected transaction", '0, rsp);
				end else begin
					e = expected_rsp_q.pop_front();
					if (rsp.out_value !== e.out_value || rsp.status !== e.status ||
					    rsp.element_count !== e.element_count || rsp.last !== e.last)
						note_mismatch("result mismatch", e, rsp);
				end
			end
			if (req_valid && !req_stall)
				apply_action(req);
		end
		fail_count  <= errors;
		outstanding <= expected_rsp_q.size();
		list_len    <= list_q.size();
	end

endmodule

/* sim/tb_top.sv */
// Stimulus, flow control and verdict for the positional linked list engine.
`timescale 1ns / 1ps
module tb_top;
	import pll_pkg::*;

	typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} phase_e;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [ACT_W-1:0] INS_ACTS[3] = '{ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS};
	localparam logic [ACT_W-1:0] DEL_ACTS[3] = '{ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS};

	logic   clk;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   rsp_stall = 1'b0;
	req_t   req = '0;
	logic   req_stall;
	logic   rsp_valid;
	rsp_t   rsp;
	int     fail_count;
	int     outstanding;
	int     list_len;
	phase_e phase = PH_SLOW_SINK;
	int     hold_left = 0;
	logic   hold_done = 1'b0;
	int     cycles = 0;

	positional_linked_list_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pll_list_checker list_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.list_len    (list_len)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int source_idle_pct(input phase_e ph);
		case (ph)
			PH_SLOW_SINK:   return 13;
			PH_SLOW_SOURCE: return 72;
			default:        return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(input phase_e ph);
		case (ph)
			PH_SLOW_SINK:   return 72;
			PH_SLOW_SOURCE: return 13;
			default:        return 0;
		endcase
	endfunction

	// one long hold-off at the start of the free-running phase fills the block
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (phase == PH_FREE && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < sink_stall_pct(phase));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
	                    input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < source_idle_pct(phase)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{act, val, pos};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_results_done();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [POS_W-1:0] pick_pos(input int top);
		int r;
		r = $urandom_range(99);
		if (r < 70 && top >= 1)
			return POS_W'($urandom_range(top, 1));
		if (r < 80)
			return '0;
		if (r < 90)
			return POS_W'(top + 1);
		return POS_W'($urandom);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return {1'b0, {(VAL_W-1){1'b1}}};
			1:       return {1'b1, {(VAL_W-1){1'b0}}};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(input int ins_pct);
		int r;
		int len;
		len = list_len;
		r = $urandom_range(99);
		if (r < 8)
			send(ACT_TRAVERSE, pick_value(), pick_pos(len));
		else if (r < 18)
			send(ACT_UPDATE, pick_value(), pick_pos(len));
		else if (r < 18 + ins_pct * 82 / 100)
			send(INS_ACTS[$urandom_range(2)], pick_value(), pick_pos(len + 1));
		else
			send(DEL_ACTS[$urandom_range(2)], pick_value(), pick_pos(len));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// from the empty list: removals, update and traversal report empty until the first insert; inserts check position
		send(ACT_TRAVERSE, 32'sd0, 6'd0);
		send(ACT_DEL_HEAD, 32'sd0, 6'd1);
		send(ACT_DEL_TAIL, 32'sd0, 6'd1);
		send(ACT_DEL_POS, 32'sd0, 6'd0);
		send(ACT_UPDATE, 32'sd7, 6'd63);
		send(ACT_INS_POS, 32'sd1, 6'd0);
		send(ACT_INS_POS, 32'sd1, 6'd2);
		send(ACT_INS_POS, 32'sd0, 6'd1);
		send(ACT_INS_HEAD, 32'sh7fffffff, 6'd0);
		send(ACT_INS_TAIL, 32'sh80000000, 6'd63);
		send(ACT_INS_POS, 32'sd5, 6'd4);
		send(ACT_INS_POS, -32'sd1, 6'd2);
		send(ACT_UPDATE, 32'sd9, 6'd0);
		send(ACT_UPDATE, 32'sd9, 6'd6);
		send(ACT_UPDATE, 32'sh5555aaaa, 6'd3);
		send(ACT_TRAVERSE, 32'sd0, 6'd63);
		send(ACT_DEL_POS, 32'sd0, 6'd0);
		send(ACT_DEL_POS, 32'sd0, 6'd6);
		send(ACT_DEL_POS, 32'sd0, 6'd63);
		send(ACT_DEL_POS, 32'sd0, 6'd3);
		send(ACT_DEL_TAIL, 32'sd0, 6'd0);
		send(ACT_DEL_HEAD, 32'sd0, 6'd0);
		send(ACT_INS_POS, 32'sd3, 6'd63);
		send(ACT_TRAVERSE, 32'sd0, 6'd0);
		wait_results_done();

		// inserts only beside updates and traversals: fills the list and hits it when full
		repeat (52) send_random(100);
		wait_results_done();
		phase <= PH_SLOW_SOURCE;

		// mostly deletes: shrinks the list
		repeat (24) send_random(10);
		wait_results_done();
		phase <= PH_FREE;

		repeat (20) send_random(50);
		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
